[sv/keyed_price_table_unit_defines.svh]
// ============================================================================
// Keyed price table unit: assertion macros
// Shared assertion macros for the keyed price table RTL. Both forms sample on
// the rising edge of clk and are disabled while rst_n is low.
// ============================================================================
`ifndef KEYED_PRICE_TABLE_UNIT_DEFINES_SVH
`define KEYED_PRICE_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define KPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KPT_ASSERT_NOW(label, ante, cons, msg)
`define KPT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/kpt_pkg.sv]
// ============================================================================
// Keyed price table package
// Sizes, command codes and status codes shared by the keyed price table files.
// ============================================================================
package kpt_pkg;

    // Table size, the derived index width and the entry count width.
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = 6;

    // Payload field widths.
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 17;
    localparam int PRICE_W  = 20;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KEY_W + PRICE_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd3;

endpackage

[sv/kpt_if.sv]
// ============================================================================
// Keyed price table channels
// Valid/ready channels for command requests and for result requests.
// ============================================================================

// Command channel: one request per table operation.
interface kpt_cmd_if;
    import kpt_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;

    modport source (output valid, output cmd, output key, output price, input ready);
    modport sink   (input valid, input cmd, input key, input price, output ready);
endinterface

// Result channel: one request per completed command.
interface kpt_rsp_if;
    import kpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PRICE_W-1:0]  found_price;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output found_price, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found_price, input entry_count,
                    output ready);
endinterface

[sv/kpt_ram.sv]
// ============================================================================
// Keyed price table RAM
// Generic simple dual-port RAM: one write port and one read port with a
// registered read; the data appears in the cycle after rd_en.
// ============================================================================
module kpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/keyed_price_table_unit.sv]
// A command is taken in S_IDLE, swept in S_SCAN and S_LAST and resolved in S_EXEC, which
// registers the result; no new command is taken until S_IDLE. The sweep reads one slot a cycle.
// The rate is set by the single read port of the entry RAM, which is swept in full.
// A result waiting in the output register stalls only the write-back of the next command.
// Reset clears the slot valid bits and the entry count at once; no clearing pass.
// Key and price contents of the RAM are not reset.
// ============================================================================
// Keyed price table unit
// Bounded keyed table of prices in cents. Each command sweeps the entry RAM
// for a matching key and the lowest free slot, then updates the table where needed and reports.
// ============================================================================
`include "keyed_price_table_unit_defines.svh"

module keyed_price_table_unit (
    input  logic     clk,
    input  logic     rst_n,
    kpt_cmd_if.sink  command,
    kpt_rsp_if.source result
);
    import kpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_EXEC
    } state_t;

    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(CAPACITY);

    // Control state.
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0]  used_cnt_reg, used_cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers.
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [PRICE_W-1:0]  hit_price_reg, hit_price_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PRICE_W-1:0]  out_price_reg, out_price_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // RAM ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [KEY_W-1:0]    rd_key;
    logic                out_free;

    // Entry RAM: key in the upper bits, price in the lower bits.
    kpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_cnt_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_key   = ram_rd_data[ENTRY_W-1:PRICE_W];
    assign out_free = !out_valid_reg || result.ready;

    // Port drive.
    assign command.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.found_price = out_price_reg;
    assign result.entry_count = out_count_reg;

    // Sweep, match tracking and write-back.
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        chk_vld_next    = (state_reg == S_SCAN);
        chk_idx_next    = scan_cnt_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_price_next  = hit_price_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        used_cnt_next   = used_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_price_next  = out_price_reg;
        out_count_next  = out_count_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        price_next      = price_reg;
        ram_rd_en       = 1'b0;
        ram_we          = 1'b0;
        ram_wr_addr     = free_idx_reg;
        ram_wr_data     = {key_reg, price_reg};

        // The result register empties when the sink takes it.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Check the slot read in the previous cycle.
        if (chk_vld_reg)
        begin
            if (valid_reg[chk_idx_reg] && (rd_key == key_reg))
            begin
                hit_next       = 1'b1;
                hit_idx_next   = chk_idx_reg;
                hit_price_next = ram_rd_data[PRICE_W-1:0];
            end
            if (!valid_reg[chk_idx_reg] && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (command.valid)
                begin
                    cmd_next      = command.cmd;
                    key_next      = command.key;
                    price_next    = command.price;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ram_rd_en = 1'b1;
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_status_next = STAT_DONE;
                    out_price_next  = '0;
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                out_status_next = STAT_DUP;
                            end
                            else if (!free_reg || (used_cnt_reg >= FULL_CNT))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we                   = 1'b1;
                                ram_wr_addr              = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                used_cnt_next            = used_cnt_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!hit_reg)
                            begin
                                out_status_next = STAT_NONE;
                            end
                            else
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                if (used_cnt_reg != '0)
                                begin
                                    used_cnt_next = used_cnt_reg - 1'b1;
                                end
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (!hit_reg)
                            begin
                                out_status_next = STAT_NONE;
                            end
                            else
                            begin
                                out_price_next = hit_price_reg;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (!hit_reg)
                            begin
                                out_status_next = STAT_NONE;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_wr_addr = hit_idx_reg;
                            end
                        end
                    endcase
                    out_count_next = used_cnt_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    // State machine and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            used_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            valid_reg     <= valid_next;
            used_cnt_reg  <= used_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        price_reg      <= price_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_price_reg  <= hit_price_next;
        free_idx_reg   <= free_idx_next;
        out_status_reg <= out_status_next;
        out_price_reg  <= out_price_next;
        out_count_reg  <= out_count_next;
    end

    // The entry count always matches the number of valid slots.
    `KPT_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_reg) == used_cnt_reg, "entry count differs from valid slots")
    // The entry count never exceeds the table size.
    `KPT_ASSERT_NOW(a_count_bound, 1'b1, used_cnt_reg <= FULL_CNT, "entry count above capacity")
    // A completed write-back always presents a result in the next cycle.
    `KPT_ASSERT_NEXT(a_exec_gives_result, (state_reg == S_EXEC) && out_free, out_valid_reg && (state_reg == S_IDLE), "write-back without result")
    // Only a successful lookup reports a non-zero price.
    `KPT_ASSERT_NOW(a_price_only_on_done, out_valid_reg && (out_status_reg != STAT_DONE), out_price_reg == '0, "price reported on failed command")

endmodule
